FILE: src/mtgen_pkg.sv
// shared types, constants and functions of the mt19937 generator
package mtgen_pkg;

  localparam int unsigned StateSizeDefault = 624;
  localparam int unsigned TwOffset         = 397;
  localparam logic [31:0] InitMult         = 32'd1812433253;
  localparam logic [31:0] UpperMask        = 32'h8000_0000;
  localparam logic [31:0] LowerMask        = 32'h7fff_ffff;
  localparam logic [31:0] TwMatrix         = 32'h9908_b0df;
  localparam logic [31:0] TemperB          = 32'h9d2c_5680;
  localparam logic [31:0] TemperC          = 32'hefc6_0000;
  localparam logic [31:0] DefaultSeedRst   = 32'd5489;

  localparam logic ModeGenerate = 1'b0;
  localparam logic ModeSeed     = 1'b1;

  typedef struct packed {
    logic seed_load;
    logic use_default;
    logic seed_mul;
    logic seed_wr;
    logic tw_prime;
    logic tw_read;
    logic tw_wr;
    logic gen_read;
    logic gen_out;
  } mtgen_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic idx_exh;
    logic out_free;
  } mtgen_sts_t;

  function automatic logic [31:0] mt_mix(input logic [31:0] hi_src,
                                         input logic [31:0] lo_src,
                                         input logic [31:0] far);
    logic [31:0] y;
    y = (hi_src & UpperMask) | (lo_src & LowerMask);
    return far ^ (y >> 1) ^ (y[0] ? TwMatrix : 32'd0);
  endfunction

  function automatic logic [31:0] mt_temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in ^ (y_in >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: src/mtgen_dp.sv
// datapath: state memory, seed multiplier, twist step, tempering and output register
module mtgen_dp import mtgen_pkg::*; #(
  parameter int unsigned StateSize = StateSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mtgen_cmd_t  cmd_i,
  output mtgen_sts_t  sts_o,
  input  logic [31:0] seed_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_data_o
);

  localparam int unsigned AddrW = $clog2(StateSize);
  localparam int unsigned IdxW  = $clog2(StateSize + 1);

  logic [31:0] mem [StateSize];

  logic [31:0]      dflt_seed_q;
  logic [31:0]      prev_q;
  logic [31:0]      prod_q;
  logic [31:0]      cur_q;
  logic [31:0]      rda_q;
  logic [31:0]      rdb_q;
  logic [AddrW-1:0] cnt_q;
  logic [IdxW-1:0]  idx_q;
  logic             out_valid_q;
  logic [31:0]      out_data_q;

  logic [31:0]      seed_sel;
  logic [31:0]      seed_word;
  logic [AddrW-1:0] nxt_addr;
  logic [AddrW:0]   far_sum;
  logic [AddrW-1:0] far_addr;
  logic [AddrW-1:0] raddr_a;
  logic             re_a;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [31:0]      wdata;
  logic             cnt_last;

  assign cnt_last  = (cnt_q == AddrW'(StateSize - 1));
  assign seed_sel  = cmd_i.use_default ? dflt_seed_q : seed_i;
  assign seed_word = prod_q + 32'(cnt_q);
  assign nxt_addr  = cnt_last ? '0 : cnt_q + AddrW'(1);
  assign far_sum   = {1'b0, cnt_q} + (AddrW + 1)'(TwOffset);
  assign far_addr  = (far_sum >= (AddrW + 1)'(StateSize)) ?
                     AddrW'(far_sum - (AddrW + 1)'(StateSize)) : AddrW'(far_sum);

  always_comb begin
    re_a    = 1'b0;
    raddr_a = '0;
    if (cmd_i.tw_prime) begin
      re_a    = 1'b1;
    end else if (cmd_i.tw_read) begin
      re_a    = 1'b1;
      raddr_a = nxt_addr;
    end else if (cmd_i.gen_read) begin
      re_a    = 1'b1;
      raddr_a = idx_q[AddrW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = seed_word;
    if (cmd_i.seed_load) begin
      we    = 1'b1;
      waddr = '0;
      wdata = seed_sel;
    end else if (cmd_i.seed_wr) begin
      we    = 1'b1;
    end else if (cmd_i.tw_wr) begin
      we    = 1'b1;
      wdata = mt_mix(cur_q, rda_q, rdb_q);
    end
  end

  // state memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rda_q <= mem[raddr_a];
    end
    if (cmd_i.tw_read) begin
      rdb_q <= mem[far_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      prev_q <= seed_sel;
    end else if (cmd_i.seed_wr) begin
      prev_q <= seed_word;
    end
    if (cmd_i.seed_mul) begin
      prod_q <= InitMult * (prev_q ^ (prev_q >> 30));
    end
    if (cmd_i.tw_read) begin
      cur_q <= rda_q;
    end
    if (cmd_i.gen_out) begin
      out_data_q <= mt_temper(rda_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_seed_q <= DefaultSeedRst;
      cnt_q       <= '0;
      idx_q       <= IdxW'(StateSize);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_seed_q <= cfg_wdata_i;
      end
      if (cmd_i.seed_load) begin
        cnt_q <= AddrW'(1);
        idx_q <= IdxW'(StateSize);
      end else if (cmd_i.seed_wr) begin
        cnt_q <= cnt_q + AddrW'(1);
      end else if (cmd_i.tw_prime) begin
        cnt_q <= '0;
      end else if (cmd_i.tw_wr) begin
        if (cnt_last) begin
          cnt_q <= '0;
          idx_q <= '0;
        end else begin
          cnt_q <= cnt_q + AddrW'(1);
        end
      end else if (cmd_i.gen_out) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.gen_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.cnt_last = cnt_last;
  assign sts_o.idx_exh  = (idx_q >= IdxW'(StateSize));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/mtgen_ctrl.sv
// controller: sequences seeding, twist pass and word read
module mtgen_ctrl import mtgen_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       mode_i,
  input  mtgen_sts_t sts_i,
  output mtgen_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSeedMul,
    StSeedWr,
    StTwPrime,
    StTwRead,
    StTwWr,
    StGenRead,
    StGenOut
  } state_e;

  state_e state_q, state_d;
  logic   seeded_q, seeded_d;
  logic   gen_pend_q, gen_pend_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    seeded_d   = seeded_q;
    gen_pend_d = gen_pend_q;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (mode_i == ModeSeed) begin
            cmd_o.seed_load = 1'b1;
            seeded_d        = 1'b1;
            gen_pend_d      = 1'b0;
            state_d         = StSeedMul;
          end else if (!seeded_q) begin
            cmd_o.seed_load   = 1'b1;
            cmd_o.use_default = 1'b1;
            seeded_d          = 1'b1;
            gen_pend_d        = 1'b1;
            state_d           = StSeedMul;
          end else if (sts_i.idx_exh) begin
            state_d = StTwPrime;
          end else begin
            state_d = StGenRead;
          end
        end
      end
      StSeedMul: begin
        cmd_o.seed_mul = 1'b1;
        state_d        = StSeedWr;
      end
      StSeedWr: begin
        cmd_o.seed_wr = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = gen_pend_q ? StTwPrime : StIdle;
        end else begin
          state_d = StSeedMul;
        end
      end
      StTwPrime: begin
        cmd_o.tw_prime = 1'b1;
        state_d        = StTwRead;
      end
      StTwRead: begin
        cmd_o.tw_read = 1'b1;
        state_d       = StTwWr;
      end
      StTwWr: begin
        cmd_o.tw_wr = 1'b1;
        state_d     = sts_i.cnt_last ? StGenRead : StTwRead;
      end
      StGenRead: begin
        cmd_o.gen_read = 1'b1;
        state_d        = StGenOut;
      end
      StGenOut: begin
        if (sts_i.out_free) begin
          cmd_o.gen_out = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      seeded_q   <= 1'b0;
      gen_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      seeded_q   <= seeded_d;
      gen_pend_q <= gen_pend_d;
    end
  end

endmodule

FILE: src/mersenne_twister_generator.sv
// top level of the mt19937 word generator
//
//  channel  dir  signals                         beat content
//  s_axis   in   tvalid/tready/tdata/tuser       tuser: mode, tdata: seed_value
//  m_axis   out  tvalid/tready/tdata             tdata: random_word
//  cfg      in   cfg_we_i/cfg_wdata_i            default_seed, no handshake
//
// generate with words left: the accepted beat passes StGenRead, then StGenOut, which waits for a free output register
// seeding writes the seed as word 0, then does one multiply and one write per word
// a twist pass primes the read, then does a read and a write per word on the memory
// a generate before any seed first seeds from default_seed, then twists
// reset leaves the state unseeded, a beat is taken in the first cycle after reset
// the next beat is taken while a result waits; a stalled result holds the next generate and every beat behind it
module mersenne_twister_generator import mtgen_pkg::*; #(
  parameter int unsigned StateSize = StateSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] seed_value
  input  logic        s_axis_tuser_i,   // [0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] random_word
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  mtgen_cmd_t cmd;
  mtgen_sts_t sts;

  mtgen_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .mode_i     (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mtgen_dp #(
    .StateSize (StateSize)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

FILE: verif/tb_mersenne_twister_generator.sv
// self-checking testbench of the mt19937 word generator with a scoreboard and random stimulus
`timescale 1ns / 1ps

module tb_mersenne_twister_generator;
  import mtgen_pkg::*;

  localparam int unsigned NumWords    = StateSizeDefault;
  localparam int unsigned PassCycles  = 2 * NumWords + 1;
  localparam int unsigned QuietCycles = 2 * PassCycles + 16;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned HoldCycles  = 4000;

  class mt_scoreboard;
    logic [31:0] words[NumWords];
    int unsigned rd_idx;
    bit          seeded;
    logic [31:0] dflt_seed;
    logic [31:0] expected_words[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned seeds;
    int unsigned beats_in;

    function new();
      dflt_seed = DefaultSeedRst;
      rd_idx    = NumWords;
      seeded    = 1'b0;
      errors    = 0;
      checked   = 0;
      seeds     = 0;
      beats_in  = 0;
    endfunction

    function void set_default_seed(logic [31:0] v);
      dflt_seed = v;
    endfunction

    function void fill_state(logic [31:0] s);
      logic [31:0] p;
      words[0] = s;
      for (int k = 1; k < NumWords; k++) begin
        p = words[k-1];
        words[k] = InitMult * (p ^ (p >> 30)) + 32'(k);
      end
      rd_idx = NumWords;
      seeded = 1'b1;
    endfunction

    function void twist_state();
      logic [31:0] y;
      for (int k = 0; k < NumWords; k++) begin
        y = (words[k] & UpperMask) | (words[(k + 1) % NumWords] & LowerMask);
        words[k] = words[(k + TwOffset) % NumWords] ^ (y >> 1) ^ (y[0] ? TwMatrix : 32'd0);
      end
      rd_idx = 0;
    endfunction

    function logic [31:0] temper_word(logic [31:0] w);
      logic [31:0] t;
      t = w ^ (w >> 11);
      t = t ^ ((t << 7) & TemperB);
      t = t ^ ((t << 15) & TemperC);
      t = t ^ (t >> 18);
      return t;
    endfunction

    function void note_input(logic mode, logic [31:0] seed_v);
      beats_in++;
      if (mode == ModeSeed) begin
        seeds++;
        fill_state(seed_v);
      end else begin
        if (!seeded) fill_state(dflt_seed);
        if (rd_idx >= NumWords) twist_state();
        expected_words.push_back(temper_word(words[rd_idx]));
        rd_idx++;
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected random_word beat: expected none, actual %08h", $time, got);
      end else begin
        exp_w = expected_words.pop_front();
        checked++;
        if (got !== exp_w) begin
          errors++;
          $display("%0t: random_word mismatch: expected %08h, actual %08h", $time, exp_w, got);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        s_user = ModeGenerate;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  mt_scoreboard sb = new();
  int unsigned  idle_cycles = 0;
  int unsigned  items_sent = 0;
  bit           send_calm = 1'b0;
  bit           recv_calm = 1'b0;

  mersenne_twister_generator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (cfg_we) sb.set_default_seed(cfg_wdata);
    if (s_valid && s_ready) sb.note_input(s_user, s_data);
    if (m_valid && m_ready) sb.check_result(m_data);
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] draw_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(input logic mode, input logic [31:0] data);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= mode;
    s_data  <= data;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic write_default_seed(input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_run(input int unsigned n);
    for (int i = 0; i < n; i++) send_beat(ModeGenerate, $urandom);
  endtask

  // receiver: random gaps, one long hold-off once results are flowing
  initial begin
    int unsigned gap;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && sb.checked >= 60) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
    end
  end

  initial begin
    logic [31:0] first_dflt;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    case ($urandom_range(0, 2))
      0: first_dflt = 32'h0000_0000;
      1: first_dflt = 32'hffff_ffff;
      default: first_dflt = $urandom;
    endcase
    write_default_seed(32'h0000_0000);
    write_default_seed(32'hffff_ffff);
    write_default_seed(first_dflt);

    // generate before any seed, seed_value ignored
    send_beat(ModeGenerate, $urandom);
    send_beat(ModeGenerate, 32'hffff_ffff);
    send_beat(ModeGenerate, 32'h0000_0000);
    send_beat(ModeSeed, 32'h0000_0000);
    send_run(2);
    send_beat(ModeSeed, 32'hffff_ffff);
    send_run(2);
    send_beat(ModeSeed, DefaultSeedRst);
    send_run(1);
    // back-to-back reseed
    send_beat(ModeSeed, 32'h0000_0001);
    send_beat(ModeSeed, 32'h8000_0000);
    send_beat(ModeGenerate, 32'h5555_5555);
    send_beat(ModeGenerate, 32'haaaa_aaaa);

    wait_drained();
    write_default_seed(32'hffff_ffff);

    items_sent = 0;
    while (items_sent < RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'($urandom_range(0, 1)), $urandom);
      end else begin
        send_beat(ModeSeed, draw_seed());
        send_run($urandom_range(1, 30));
      end
      if (items_sent >= RandomItems / 2 && items_sent < RandomItems / 2 + 40) begin
        wait_drained();
        write_default_seed($urandom);
        items_sent = RandomItems / 2 + 40;
      end
    end

    // run across the twist boundary after one full pass of the state
    wait_drained();
    write_default_seed(32'h0000_0000);
    send_beat(ModeSeed, $urandom);
    send_run(NumWords + 8);

    wait_drained();
    $display("covered %0d input beats, %0d seed loads, %0d words checked",
             sb.beats_in, sb.seeds, sb.checked);
    $display("default seed writes, reseeds, stalls and a twist-boundary run were exercised");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: mersenne_twister_generator.f
src/mtgen_pkg.sv
src/mtgen_dp.sv
src/mtgen_ctrl.sv
src/mersenne_twister_generator.sv
verif/tb_mersenne_twister_generator.sv
